>>> sv/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers used by the checker file.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every clock edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

// Checked only while the active-low reset is released.
`define ASSERT_RUN(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error(msg);

`endif

>>> sv/m2ad_pkg.sv
// ---------------------------------------------------------------------------
// m2ad_pkg
// Types, constants and the small divider shared by the downsampler files.
// ---------------------------------------------------------------------------
package m2ad_pkg;

    localparam int PIX_W   = 8;             // one colour channel
    localparam int SUM2_W  = PIX_W + 1;     // sum of two pixels
    localparam int SUM4_W  = PIX_W + 2;     // sum of four pixels
    localparam int CNT2_W  = 2;             // lit count of two pixels, 0..2
    localparam int CNT4_W  = 3;             // lit count of four pixels, 0..4
    localparam int CFG_W   = 10;
    localparam int DATA_W  = 3 * PIX_W;

    localparam int DEF_MAX_WIDTH = 512;
    localparam int QUEUE_DEPTH   = 4;
    localparam logic [CFG_W-1:0] LINE_WIDTH_RESET = 10'd512;

    // floor(x / 3) = (x * 683) >> 11, exact for x up to 1020
    localparam int RECIP3       = 683;
    localparam int RECIP3_W     = 10;
    localparam int RECIP3_SHIFT = 11;

    // Channel sums and lit count of a horizontal pixel pair
    typedef struct packed {
        logic [CNT2_W-1:0] n;
        logic [SUM2_W-1:0] b;
        logic [SUM2_W-1:0] g;
        logic [SUM2_W-1:0] r;
    } t_pair;

    // What the front hands to the back for each completed pair
    typedef struct packed {
        t_pair pair;
        logic  lower;   // pair belongs to the lower row of the block
        logic  last;    // last block of the frame
    } t_cmd;

    function automatic logic [PIX_W-1:0] div_by_count(input logic [SUM4_W-1:0] s,
                                                      input logic [CNT4_W-1:0] n);
        logic [SUM4_W+RECIP3_W-1:0] p;
        logic [PIX_W-1:0]           q;
        p = {{RECIP3_W{1'b0}}, s} * (SUM4_W + RECIP3_W)'(RECIP3);
        unique case (n)
            3'd1:    q = s[PIX_W-1:0];
            3'd2:    q = s[PIX_W:1];
            3'd3:    q = p[RECIP3_SHIFT +: PIX_W];
            3'd4:    q = s[PIX_W+1:2];
            default: q = '0;    // all four black
        endcase
        return q;
    endfunction

endpackage

>>> sv/m2ad_ram.sv
// ---------------------------------------------------------------------------
// m2ad_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
module m2ad_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 256,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]  i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> sv/m2ad_queue.sv
// ---------------------------------------------------------------------------
// m2ad_queue
// Short register FIFO between the front and the back.
// ---------------------------------------------------------------------------
module m2ad_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic             o_valid,
    output logic             o_full,
    output logic [WIDTH-1:0] o_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]    r_count, n_count;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + CW'(1);
        end else if (i_pop && !i_push) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    assign o_valid = (r_count != '0);
    assign o_full  = (r_count == CW'(DEPTH));
    assign o_data  = r_mem[r_rd_ptr];

endmodule

>>> sv/m2ad_front.sv
// ---------------------------------------------------------------------------
// m2ad_front
// Pixel intake: raster position, line width, horizontal pair sums.
// ---------------------------------------------------------------------------
module m2ad_front #(
    parameter int MAX_WIDTH = m2ad_pkg::DEF_MAX_WIDTH,
    parameter int AW        = $clog2(MAX_WIDTH / 2)
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_wr,
    input  logic [m2ad_pkg::CFG_W-1:0]   i_cfg_data,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [m2ad_pkg::PIX_W-1:0]   i_red,
    input  logic [m2ad_pkg::PIX_W-1:0]   i_green,
    input  logic [m2ad_pkg::PIX_W-1:0]   i_blue,
    input  logic                         i_full,
    output logic                         o_push,
    output m2ad_pkg::t_cmd               o_cmd,
    output logic [AW-1:0]                o_slot
);

    import m2ad_pkg::*;

    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int WW   = $clog2(MAX_WIDTH + 1);
    localparam int CMPW = (WW > CFG_W) ? WW : CFG_W;

    logic [CFG_W-1:0] r_line_width;
    logic [CW-1:0]    r_col, n_col;
    logic [CW-1:0]    r_row, n_row;
    t_pair            r_pend;

    logic [CMPW-1:0]  lw_ext, w_clamp;
    logic [WW-1:0]    w_use, col_inc, row_inc;
    logic             col_end, row_end, accept;
    t_pair            pix, pair;

    // width clamped to 2..MAX_WIDTH, then made even
    always_comb begin
        lw_ext = CMPW'(r_line_width);
        if (lw_ext < CMPW'(2)) begin
            w_clamp = CMPW'(2);
        end else if (lw_ext > CMPW'(MAX_WIDTH)) begin
            w_clamp = CMPW'(MAX_WIDTH);
        end else begin
            w_clamp = lw_ext;
        end
        w_use = {w_clamp[WW-1:1], 1'b0};
    end

    assign col_inc = WW'(r_col) + WW'(1);
    assign row_inc = WW'(r_row) + WW'(1);
    assign col_end = (col_inc >= w_use);
    assign row_end = (row_inc >= w_use);

    assign o_ready = !i_full;
    assign accept  = i_valid && o_ready;

    // a black pixel contributes zero to every sum anyway
    always_comb begin
        pix.r = {1'b0, i_red};
        pix.g = {1'b0, i_green};
        pix.b = {1'b0, i_blue};
        pix.n = {1'b0, |{i_red, i_green, i_blue}};
        pair.r = r_pend.r + pix.r;
        pair.g = r_pend.g + pix.g;
        pair.b = r_pend.b + pix.b;
        pair.n = r_pend.n + pix.n;
    end

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (col_end) begin
            n_col = '0;
            n_row = row_end ? '0 : CW'(row_inc);
        end else begin
            n_col = CW'(col_inc);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_width <= LINE_WIDTH_RESET;
            r_col        <= '0;
            r_row        <= '0;
            r_pend       <= '0;
        end else if (i_cfg_wr) begin
            r_line_width <= i_cfg_data;
            r_col        <= '0;
            r_row        <= '0;
            r_pend       <= '0;
        end else if (accept) begin
            r_col <= n_col;
            r_row <= n_row;
            if (!r_col[0]) begin
                r_pend <= pix;
            end
        end
    end

    assign o_push      = accept && r_col[0];
    assign o_cmd.pair  = pair;
    assign o_cmd.lower = r_row[0];
    assign o_cmd.last  = col_end && row_end;
    assign o_slot      = AW'(r_col >> 1);

endmodule

>>> sv/m2ad_back.sv
// ---------------------------------------------------------------------------
// m2ad_back
// Upper-row pair store, block sum, masked average and output register.
// ---------------------------------------------------------------------------
module m2ad_back #(
    parameter int MAX_WIDTH = m2ad_pkg::DEF_MAX_WIDTH,
    parameter int AW        = $clog2(MAX_WIDTH / 2)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_q_valid,
    input  m2ad_pkg::t_cmd                i_cmd,
    input  logic [AW-1:0]                 i_slot,
    output logic                          o_pop,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [m2ad_pkg::DATA_W-1:0]   o_data,
    output logic                          o_last
);

    import m2ad_pkg::*;

    localparam int DEPTH = MAX_WIDTH / 2;
    localparam int PW    = $bits(t_pair);

    logic            r_s1_valid;
    t_pair           r_s1_pair;
    logic            r_s1_last;
    logic            r_out_valid;
    logic [DATA_W-1:0] r_out_data;
    logic            r_out_last;

    logic [PW-1:0]     rd_data;
    t_pair             up;
    logic              out_free, s1_free;
    logic [SUM4_W-1:0] sum_r, sum_g, sum_b;
    logic [CNT4_W-1:0] cnt;
    logic [DATA_W-1:0] avg;

    assign out_free = !r_out_valid || i_ready;
    assign s1_free  = !r_s1_valid || out_free;
    assign o_pop    = i_q_valid && s1_free;

    m2ad_ram #(
        .WIDTH  (PW),
        .DEPTH  (DEPTH),
        .ADDR_W (AW)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (o_pop && !i_cmd.lower),
        .i_wr_addr (i_slot),
        .i_wr_data (i_cmd.pair),
        .i_rd_en   (o_pop && i_cmd.lower),
        .i_rd_addr (i_slot),
        .o_rd_data (rd_data)
    );

    // upper pair arrives from the store in the cycle after the read
    always_comb begin
        up    = t_pair'(rd_data);
        sum_r = SUM4_W'(up.r) + SUM4_W'(r_s1_pair.r);
        sum_g = SUM4_W'(up.g) + SUM4_W'(r_s1_pair.g);
        sum_b = SUM4_W'(up.b) + SUM4_W'(r_s1_pair.b);
        cnt   = CNT4_W'(up.n) + CNT4_W'(r_s1_pair.n);
        avg   = {div_by_count(sum_b, cnt), div_by_count(sum_g, cnt),
                 div_by_count(sum_r, cnt)};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s1_free) begin
                r_s1_valid <= o_pop && i_cmd.lower;
            end
            if (out_free) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_free) begin
            r_s1_pair <= i_cmd.pair;
            r_s1_last <= i_cmd.last;
        end
        if (out_free && r_s1_valid) begin
            r_out_data <= avg;
            r_out_last <= r_s1_last;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out_data;
    assign o_last  = r_out_last;

endmodule

>>> sv/masked_2x2_average_downsample_unit.sv
// ---------------------------------------------------------------------------
// masked_2x2_average_downsample_unit
// Halves a square RGB frame, averaging only the non-black pixels of each 2x2.
// ---------------------------------------------------------------------------
// Pixels arrive in raster order, one per transfer, for a line_width x
// line_width frame (line_width is clamped to 2..MAX_WIDTH and rounded down to
// even). One result follows the transfer of the bottom-right pixel of every
// 2x2 block; tlast marks the last block of the frame. The sustained rate is
// one pixel per clock while the output is not held off. The pair holding the
// bottom-right pixel is written to the queue at the edge of its transfer, is
// read out into the stage-one register together with the upper-row pair from
// the store, and the sum and divide then land in the output register.
// A four-entry queue sits between front and back; when the output is held
// off the queue fills and o_s_tready falls. The upper row of each block is
// kept as pair sums in a MAX_WIDTH/2 entry RAM, which needs no clearing: each
// entry is written in an upper row before the lower row reads it. Writing the
// configuration register restarts the frame at its top-left pixel and must
// only be done while the block is idle; o_cfg_ready is always high.
// ---------------------------------------------------------------------------
module masked_2x2_average_downsample_unit #(
    parameter int MAX_WIDTH = m2ad_pkg::DEF_MAX_WIDTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration: line_width
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [m2ad_pkg::CFG_W-1:0]    i_cfg_data,
    // pixel input
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic [m2ad_pkg::DATA_W-1:0]   i_s_tdata,  // red, green, blue
    // downsampled output
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [m2ad_pkg::DATA_W-1:0]   o_m_tdata,  // out_red, out_green, out_blue
    output logic                          o_m_tlast   // frame_end
);

    import m2ad_pkg::*;

    localparam int AW = $clog2(MAX_WIDTH / 2);
    localparam int QW = $bits(t_cmd) + AW;

    logic          push, pop, q_valid, q_full;
    t_cmd          f_cmd, b_cmd;
    logic [AW-1:0] f_slot, b_slot;
    logic [QW-1:0] q_out;

    assign o_cfg_ready = 1'b1;

    m2ad_front #(
        .MAX_WIDTH (MAX_WIDTH),
        .AW        (AW)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_wr   (i_cfg_valid && o_cfg_ready),
        .i_cfg_data (i_cfg_data),
        .i_valid    (i_s_tvalid),
        .o_ready    (o_s_tready),
        .i_red      (i_s_tdata[PIX_W-1:0]),
        .i_green    (i_s_tdata[2*PIX_W-1:PIX_W]),
        .i_blue     (i_s_tdata[3*PIX_W-1:2*PIX_W]),
        .i_full     (q_full),
        .o_push     (push),
        .o_cmd      (f_cmd),
        .o_slot     (f_slot)
    );

    // one entry per completed horizontal pair
    m2ad_queue #(
        .WIDTH (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  ({f_slot, f_cmd}),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_full  (q_full),
        .o_data  (q_out)
    );

    assign b_cmd  = t_cmd'(q_out[$bits(t_cmd)-1:0]);
    assign b_slot = q_out[QW-1:$bits(t_cmd)];

    m2ad_back #(
        .MAX_WIDTH (MAX_WIDTH),
        .AW        (AW)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_cmd     (b_cmd),
        .i_slot    (b_slot),
        .o_pop     (pop),
        .o_valid   (o_m_tvalid),
        .i_ready   (i_m_tready),
        .o_data    (o_m_tdata),
        .o_last    (o_m_tlast)
    );

endmodule

>>> sv/m2ad_checker.sv
// ---------------------------------------------------------------------------
// m2ad_checker
// Port-level assertions for the downsampler, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module m2ad_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_s_tready,
    input logic                          o_m_tvalid,
    input logic                          i_m_tready,
    input logic [m2ad_pkg::DATA_W-1:0]   o_m_tdata,
    input logic                          o_m_tlast
);

    // a held result stays offered
    `ASSERT_RUN(a_out_hold, i_clk, i_rst_n, o_m_tvalid && !i_m_tready |=> o_m_tvalid, "result dropped while stalled")

    // and keeps its payload
    `ASSERT_RUN(a_out_stable, i_clk, i_rst_n, o_m_tvalid && !i_m_tready |=> $stable(o_m_tdata) && $stable(o_m_tlast), "stalled result changed")

    // pipeline is empty after reset, so no result is offered straight after it
    `ASSERT_ALWAYS(a_rst_quiet, i_clk, !i_rst_n |=> !o_m_tvalid ##1 !o_m_tvalid ##1 !o_m_tvalid, "result too soon after reset")

    // queue is empty after reset, so input is taken at once
    `ASSERT_ALWAYS(a_rst_ready, i_clk, !i_rst_n |=> o_s_tready, "input not ready after reset")

endmodule

bind masked_2x2_average_downsample_unit m2ad_checker u_m2ad_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tlast  (o_m_tlast)
);
